### rtl/smsi_pkg.sv
// Shared constants, state encodings and control structures for the sample statistics block.
package smsi_pkg;

   // Data set and number format.
   localparam int MAX_SAMPLES = 4096;
   localparam int SAMPLE_W    = 16;
   localparam int FRAC_W      = 16;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int SUM_W       = 28;

   // Internal datapath widths.
   localparam int MEAN_W = 33;
   localparam int DIFF_W = 34;
   localparam int AD_W   = 32;
   localparam int SABS_W = 45;
   localparam int SSQ_W  = 60;
   localparam int VAR_W  = 48;
   localparam int SDEV_W = 32;
   localparam int Z_W    = 24;
   localparam int A2_W   = 32;
   localparam int A3_W   = 40;
   localparam int S3_W   = 54;
   localparam int S4_W   = 60;
   localparam int MUL_W  = 32;
   localparam int PROD_W = 64;
   localparam int DVD_W  = 64;
   localparam int DVS_W  = 32;
   localparam int OUT_W  = 32;

   // Excess kurtosis offset, three in fixed point.
   localparam logic [OUT_W-1:0] KURT_OFFSET = OUT_W'(3) << FRAC_W;

   // Configuration port.
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic CSR_IGN_EN  = 1'b0;
   localparam logic CSR_IGN_VAL = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MEAN,
      ST_P1_ADDR,
      ST_P1_DIFF,
      ST_P1_MUL,
      ST_P1_ACC,
      ST_P1_END,
      ST_ADEV,
      ST_VAR,
      ST_SQRT_GO,
      ST_SQRT,
      ST_P2_CHECK,
      ST_P2_ADDR,
      ST_P2_DIFF,
      ST_P2_ZGO,
      ST_P2_ZDIV,
      ST_P2_SQ,
      ST_P2_A2,
      ST_P2_CUBE,
      ST_P2_A3,
      ST_P2_A4,
      ST_P2_END,
      ST_SKEW,
      ST_KURT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MUL_AD_AD,
      MUL_Z_Z,
      MUL_A2_Z,
      MUL_A2_A2
   } mul_sel_type;

   typedef enum logic [2:0] {
      DIV_MEAN,
      DIV_ADEV,
      DIV_VAR,
      DIV_Z,
      DIV_SKEW,
      DIV_KURT
   } div_sel_type;

   typedef enum logic [2:0] {
      CAP_NONE,
      CAP_MEAN,
      CAP_ADEV,
      CAP_VAR,
      CAP_SDEV,
      CAP_Z,
      CAP_SKEW,
      CAP_KURT
   } cap_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        take;
      logic        clr_stats;
      logic        clr_acc;
      logic        load_out;
      logic        idx_clr;
      logic        idx_inc;
      logic        diff;
      logic        p1_acc;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        div_start;
      div_sel_type div_sel;
      logic        sqrt_start;
      cap_type     cap;
      logic        a2_lat;
      logic        s3_acc;
      logic        s4_acc;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic n_ge2;
      logic idx_last;
      logic div_done;
      logic sqrt_done;
      logic pass2_ok;
   } status_type;

endpackage

### rtl/smsi_if.sv
// Valid/ready channel interfaces for sample beats and result beats.
interface smsi_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [smsi_pkg::SAMPLE_W-1:0] sample;
   logic                                 last;

   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

interface smsi_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [smsi_pkg::SAMPLE_W-1:0] minimum;
   logic signed [smsi_pkg::SAMPLE_W-1:0] maximum;
   logic signed [smsi_pkg::OUT_W-1:0]    mean;
   logic [smsi_pkg::OUT_W-1:0]           avg_deviation;
   logic [smsi_pkg::OUT_W-1:0]           std_deviation;
   logic [smsi_pkg::VAR_W-1:0]           variance;
   logic signed [smsi_pkg::OUT_W-1:0]    skewness;
   logic signed [smsi_pkg::OUT_W-1:0]    kurtosis;
   logic signed [smsi_pkg::SUM_W-1:0]    total;
   logic [smsi_pkg::CNT_W-1:0]           kept_count;
   logic                                 too_few;

   modport source (output valid, output minimum, output maximum, output mean,
                   output avg_deviation, output std_deviation, output variance,
                   output skewness, output kurtosis, output total, output kept_count,
                   output too_few, input ready);
   modport sink (input valid, input minimum, input maximum, input mean,
                 input avg_deviation, input std_deviation, input variance,
                 input skewness, input kurtosis, input total, input kept_count,
                 input too_few, output ready);
endinterface

### rtl/smsi_div.sv
// Restoring divider that produces one quotient bit per cycle.
module smsi_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [smsi_pkg::DVD_W-1:0]       dividend,
   input  logic [smsi_pkg::DVS_W-1:0]       divisor,
   output logic                             done,
   output logic [smsi_pkg::DVD_W-1:0]       quotient
);

   localparam int STEP_W = $clog2(smsi_pkg::DVD_W + 1);

   logic                          busy_ff;
   logic                          done_ff;
   logic [STEP_W-1:0]             step_ff;
   logic [smsi_pkg::DVS_W-1:0]    rem_ff;
   logic [smsi_pkg::DVD_W-1:0]    quo_ff;
   logic [smsi_pkg::DVS_W-1:0]    dvs_ff;
   logic [smsi_pkg::DVS_W:0]      shifted;
   logic [smsi_pkg::DVS_W+1:0]    sub;
   logic                          ge;

   // Trial subtraction of the divisor from the shifted partial remainder.
   always_comb begin
      shifted = {rem_ff, quo_ff[smsi_pkg::DVD_W-1]};
      sub     = {1'b0, shifted} - {2'b00, dvs_ff};
      ge      = !sub[smsi_pkg::DVS_W+1];
   end

   // Iteration control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(smsi_pkg::DVD_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Remainder and quotient shift registers.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? sub[smsi_pkg::DVS_W-1:0] : shifted[smsi_pkg::DVS_W-1:0];
         quo_ff <= {quo_ff[smsi_pkg::DVD_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/smsi_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module smsi_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [smsi_pkg::DVD_W-1:0]    radicand,
   output logic                          done,
   output logic [smsi_pkg::SDEV_W-1:0]   root
);

   localparam int RW     = smsi_pkg::SDEV_W;
   localparam int STEP_W = $clog2(RW + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [RW:0]          rem_ff;
   logic [RW-1:0]        root_ff;
   logic [2*RW-1:0]      arg_ff;
   logic [RW+2:0]        tmp;
   logic [RW+2:0]        trial;
   logic [RW+3:0]        sub;
   logic                 ge;

   // Bring down two radicand bits and try the next root bit.
   always_comb begin
      tmp   = {rem_ff, arg_ff[2*RW-1:2*RW-2]};
      trial = {1'b0, root_ff, 2'b01};
      sub   = {1'b0, tmp} - {1'b0, trial};
      ge    = !sub[RW+3];
   end

   // Iteration control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(RW);
         end else if (busy_ff) begin
            step_ff <= step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Remainder, root and radicand registers.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         root_ff <= '0;
         arg_ff  <= radicand;
      end else if (busy_ff) begin
         rem_ff  <= ge ? sub[RW:0] : tmp[RW:0];
         root_ff <= {root_ff[RW-2:0], ge};
         arg_ff  <= {arg_ff[2*RW-3:0], 2'b00};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### rtl/smsi_datapath.sv
// Sample store, accumulators, shared multiplier and divide/root units of the statistics block.
module smsi_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  smsi_pkg::cmd_type                     cmd,
   output smsi_pkg::status_type                  status,
   input  logic                                  ign_en,
   input  logic signed [smsi_pkg::SAMPLE_W-1:0]  ign_val,
   input  logic signed [smsi_pkg::SAMPLE_W-1:0]  sample,
   output logic signed [smsi_pkg::SAMPLE_W-1:0]  minimum,
   output logic signed [smsi_pkg::SAMPLE_W-1:0]  maximum,
   output logic signed [smsi_pkg::OUT_W-1:0]     mean,
   output logic [smsi_pkg::OUT_W-1:0]            avg_deviation,
   output logic [smsi_pkg::OUT_W-1:0]            std_deviation,
   output logic [smsi_pkg::VAR_W-1:0]            variance,
   output logic signed [smsi_pkg::OUT_W-1:0]     skewness,
   output logic signed [smsi_pkg::OUT_W-1:0]     kurtosis,
   output logic signed [smsi_pkg::SUM_W-1:0]     total,
   output logic [smsi_pkg::CNT_W-1:0]            kept_count,
   output logic                                  too_few
);

   localparam int SW = smsi_pkg::SAMPLE_W;
   localparam int FW = smsi_pkg::FRAC_W;
   localparam int OW = smsi_pkg::OUT_W;

   // Sample store.
   logic [SW-1:0] mem [smsi_pkg::MAX_SAMPLES];
   logic [SW-1:0] rd_ff;

   // Running accumulators of the current data set.
   logic [smsi_pkg::CNT_W-1:0]        cnt_ff;
   logic signed [smsi_pkg::SUM_W-1:0] sum_ff;
   logic signed [SW-1:0]              min_ff;
   logic signed [SW-1:0]              max_ff;

   // Statistics of the second and third passes.
   logic [smsi_pkg::ADDR_W-1:0]        idx_ff;
   logic signed [smsi_pkg::MEAN_W-1:0] mean_ff;
   logic [smsi_pkg::AD_W-1:0]          ad_ff;
   logic                               neg_ff;
   logic [smsi_pkg::SABS_W-1:0]        sabs_ff;
   logic [smsi_pkg::SSQ_W-1:0]         ssq_ff;
   logic [OW-1:0]                      adev_ff;
   logic [smsi_pkg::VAR_W-1:0]         var_ff;
   logic [smsi_pkg::SDEV_W-1:0]        sdev_ff;
   logic [smsi_pkg::Z_W-1:0]           z_ff;
   logic [smsi_pkg::A2_W-1:0]          a2_ff;
   logic [smsi_pkg::PROD_W-1:0]        prod_ff;
   logic signed [smsi_pkg::S3_W-1:0]   s3_ff;
   logic [smsi_pkg::S4_W-1:0]          s4_ff;
   logic signed [OW-1:0]               skew_ff;
   logic signed [OW-1:0]               kurt_ff;

   // Result register.
   logic signed [SW-1:0]               out_min_ff;
   logic signed [SW-1:0]               out_max_ff;
   logic signed [OW-1:0]               out_mean_ff;
   logic [OW-1:0]                      out_adev_ff;
   logic [OW-1:0]                      out_sdev_ff;
   logic [smsi_pkg::VAR_W-1:0]         out_var_ff;
   logic signed [OW-1:0]               out_skew_ff;
   logic signed [OW-1:0]               out_kurt_ff;
   logic signed [smsi_pkg::SUM_W-1:0]  out_sum_ff;
   logic [smsi_pkg::CNT_W-1:0]         out_cnt_ff;
   logic                               out_few_ff;

   // Combinational values.
   logic                              keep;
   logic [smsi_pkg::SUM_W-1:0]        abs_sum;
   logic [smsi_pkg::S3_W-1:0]         abs_s3;
   logic signed [smsi_pkg::DIFF_W-1:0] dval;
   logic [smsi_pkg::DIFF_W-1:0]       dmag;
   logic [smsi_pkg::MUL_W-1:0]        mul_a;
   logic [smsi_pkg::MUL_W-1:0]        mul_b;
   logic [smsi_pkg::DVD_W-1:0]        div_dvd;
   logic [smsi_pkg::DVS_W-1:0]        div_dvs;
   logic                              div_done;
   logic [smsi_pkg::DVD_W-1:0]        div_quo;
   logic                              sqrt_done;
   logic [smsi_pkg::SDEV_W-1:0]       sqrt_root;
   logic [smsi_pkg::MEAN_W-1:0]       mean_mag;
   logic [OW-1:0]                     skew_val;
   logic [smsi_pkg::DVD_W:0]          kdiff;
   logic [OW-1:0]                     kurt_val;
   logic [smsi_pkg::A3_W-1:0]         a3;
   logic [smsi_pkg::S3_W-1:0]         a3_signed;

   // Whether the incoming sample enters the data set.
   always_comb begin
      keep = !(ign_en && (sample == ign_val)) &&
             (cnt_ff != smsi_pkg::CNT_W'(smsi_pkg::MAX_SAMPLES));
   end

   // Deviation of the stored sample from the mean, in fixed point.
   always_comb begin
      dval = $signed({{(smsi_pkg::DIFF_W-SW-FW){rd_ff[SW-1]}}, rd_ff, FW'(0)}) -
             $signed({mean_ff[smsi_pkg::MEAN_W-1], mean_ff});
      dmag = dval[smsi_pkg::DIFF_W-1] ? (~dval + 1'b1) : dval;
   end

   // Magnitudes of signed sums for the divider.
   always_comb begin
      abs_sum = sum_ff[smsi_pkg::SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
      abs_s3  = s3_ff[smsi_pkg::S3_W-1] ? (~s3_ff + 1'b1) : s3_ff;
   end

   // Multiplier operand selection.
   always_comb begin
      unique case (cmd.mul_sel)
         smsi_pkg::MUL_AD_AD: begin
            mul_a = ad_ff;
            mul_b = ad_ff;
         end
         smsi_pkg::MUL_Z_Z: begin
            mul_a = smsi_pkg::MUL_W'(z_ff);
            mul_b = smsi_pkg::MUL_W'(z_ff);
         end
         smsi_pkg::MUL_A2_Z: begin
            mul_a = a2_ff;
            mul_b = smsi_pkg::MUL_W'(z_ff);
         end
         smsi_pkg::MUL_A2_A2: begin
            mul_a = a2_ff;
            mul_b = a2_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Divider operand selection.
   always_comb begin
      unique case (cmd.div_sel)
         smsi_pkg::DIV_MEAN: begin
            div_dvd = smsi_pkg::DVD_W'({abs_sum, FW'(0)});
            div_dvs = smsi_pkg::DVS_W'(cnt_ff);
         end
         smsi_pkg::DIV_ADEV: begin
            div_dvd = smsi_pkg::DVD_W'(sabs_ff);
            div_dvs = smsi_pkg::DVS_W'(cnt_ff);
         end
         smsi_pkg::DIV_VAR: begin
            div_dvd = smsi_pkg::DVD_W'(ssq_ff);
            div_dvs = smsi_pkg::DVS_W'(cnt_ff - smsi_pkg::CNT_W'(1));
         end
         smsi_pkg::DIV_Z: begin
            div_dvd = smsi_pkg::DVD_W'({ad_ff, FW'(0)});
            div_dvs = sdev_ff;
         end
         smsi_pkg::DIV_SKEW: begin
            div_dvd = smsi_pkg::DVD_W'(abs_s3);
            div_dvs = smsi_pkg::DVS_W'(cnt_ff);
         end
         smsi_pkg::DIV_KURT: begin
            div_dvd = smsi_pkg::DVD_W'(s4_ff);
            div_dvs = smsi_pkg::DVS_W'(cnt_ff);
         end
         default: begin
            div_dvd = '0;
            div_dvs = smsi_pkg::DVS_W'(cnt_ff);
         end
      endcase
   end

   smsi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   smsi_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand ({var_ff, FW'(0)}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Signed, saturated forms of the quotients.
   always_comb begin
      mean_mag = div_quo[smsi_pkg::MEAN_W-1:0];
      if (s3_ff[smsi_pkg::S3_W-1]) begin
         if ((|div_quo[smsi_pkg::DVD_W-1:OW]) || (div_quo[OW-1] && (|div_quo[OW-2:0])))
            skew_val = {1'b1, {(OW-1){1'b0}}};
         else
            skew_val = ~div_quo[OW-1:0] + 1'b1;
      end else begin
         if (|div_quo[smsi_pkg::DVD_W-1:OW-1])
            skew_val = {1'b0, {(OW-1){1'b1}}};
         else
            skew_val = div_quo[OW-1:0];
      end
      kdiff = {1'b0, div_quo} - (smsi_pkg::DVD_W + 1)'(smsi_pkg::KURT_OFFSET);
      if (!kdiff[smsi_pkg::DVD_W] && (|kdiff[smsi_pkg::DVD_W-1:OW-1]))
         kurt_val = {1'b0, {(OW-1){1'b1}}};
      else if (kdiff[smsi_pkg::DVD_W] && !(&kdiff[smsi_pkg::DVD_W-1:OW-1]))
         kurt_val = {1'b1, {(OW-1){1'b0}}};
      else
         kurt_val = kdiff[OW-1:0];
   end

   // Third moment term with the sign of the deviation.
   always_comb begin
      a3        = prod_ff[FW +: smsi_pkg::A3_W];
      a3_signed = neg_ff ? (~smsi_pkg::S3_W'(a3) + 1'b1) : smsi_pkg::S3_W'(a3);
   end

   // Sample store write and registered read.
   always_ff @(posedge clock) begin
      if (cmd.take && keep)
         mem[cnt_ff[smsi_pkg::ADDR_W-1:0]] <= sample;
      rd_ff <= mem[idx_ff];
   end

   // Count, sum, minimum and maximum of the data set.
   always_ff @(posedge clock) begin
      if (reset || cmd.clr_acc) begin
         cnt_ff <= '0;
         sum_ff <= '0;
         min_ff <= '0;
         max_ff <= '0;
      end else if (cmd.take && keep) begin
         cnt_ff <= cnt_ff + smsi_pkg::CNT_W'(1);
         sum_ff <= sum_ff + {{(smsi_pkg::SUM_W-SW){sample[SW-1]}}, sample};
         if ((cnt_ff == '0) || (sample < min_ff))
            min_ff <= sample;
         if ((cnt_ff == '0) || (sample > max_ff))
            max_ff <= sample;
      end
   end

   // Pass index into the sample store.
   always_ff @(posedge clock) begin
      if (cmd.clr_stats || cmd.idx_clr)
         idx_ff <= '0;
      else if (cmd.idx_inc)
         idx_ff <= idx_ff + smsi_pkg::ADDR_W'(1);
   end

   // Shared multiplier with registered product.
   always_ff @(posedge clock) begin
      if (cmd.mul_en)
         prod_ff <= mul_a * mul_b;
   end

   // Deviation magnitude and sign of the current sample, and the latched square term.
   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         ad_ff  <= dmag[smsi_pkg::AD_W-1:0];
         neg_ff <= dval[smsi_pkg::DIFF_W-1];
      end
      if (cmd.a2_lat)
         a2_ff <= prod_ff[FW +: smsi_pkg::A2_W];
   end

   // Statistics registers.
   always_ff @(posedge clock) begin
      if (cmd.clr_stats) begin
         mean_ff <= '0;
         sabs_ff <= '0;
         ssq_ff  <= '0;
         adev_ff <= '0;
         var_ff  <= '0;
         sdev_ff <= '0;
         s3_ff   <= '0;
         s4_ff   <= '0;
         skew_ff <= '0;
         kurt_ff <= '0;
      end else begin
         if (cmd.p1_acc) begin
            sabs_ff <= sabs_ff + smsi_pkg::SABS_W'(ad_ff);
            ssq_ff  <= ssq_ff + smsi_pkg::SSQ_W'(prod_ff[smsi_pkg::PROD_W-1:FW]);
         end
         if (cmd.s3_acc)
            s3_ff <= s3_ff + a3_signed;
         if (cmd.s4_acc)
            s4_ff <= s4_ff + smsi_pkg::S4_W'(prod_ff[smsi_pkg::PROD_W-1:FW]);
         unique case (cmd.cap)
            smsi_pkg::CAP_NONE: begin
            end
            smsi_pkg::CAP_MEAN: begin
               mean_ff <= sum_ff[smsi_pkg::SUM_W-1] ? (~mean_mag + 1'b1) : mean_mag;
            end
            smsi_pkg::CAP_ADEV: begin
               adev_ff <= (|div_quo[smsi_pkg::DVD_W-1:OW]) ? '1 : div_quo[OW-1:0];
            end
            smsi_pkg::CAP_VAR: begin
               var_ff <= (|div_quo[smsi_pkg::DVD_W-1:smsi_pkg::VAR_W]) ? '1 :
                         div_quo[smsi_pkg::VAR_W-1:0];
            end
            smsi_pkg::CAP_SDEV: begin
               sdev_ff <= sqrt_root;
            end
            smsi_pkg::CAP_Z: begin
               z_ff <= div_quo[smsi_pkg::Z_W-1:0];
            end
            smsi_pkg::CAP_SKEW: begin
               skew_ff <= skew_val;
            end
            smsi_pkg::CAP_KURT: begin
               kurt_ff <= kurt_val;
            end
            default: begin
            end
         endcase
      end
   end

   // Result register, loaded once per data set.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_min_ff  <= min_ff;
         out_max_ff  <= max_ff;
         // The mean can reach the positive limit only when saturated.
         if (!mean_ff[smsi_pkg::MEAN_W-1] && mean_ff[OW-1])
            out_mean_ff <= {1'b0, {(OW-1){1'b1}}};
         else if (mean_ff[smsi_pkg::MEAN_W-1] && !mean_ff[OW-1])
            out_mean_ff <= {1'b1, {(OW-1){1'b0}}};
         else
            out_mean_ff <= mean_ff[OW-1:0];
         out_adev_ff <= adev_ff;
         out_sdev_ff <= sdev_ff;
         out_var_ff  <= var_ff;
         out_skew_ff <= skew_ff;
         out_kurt_ff <= kurt_ff;
         out_sum_ff  <= sum_ff;
         out_cnt_ff  <= cnt_ff;
         out_few_ff  <= (cnt_ff < smsi_pkg::CNT_W'(2));
      end
   end

   // Status toward the controller.
   always_comb begin
      status.n_ge2     = (cnt_ff >= smsi_pkg::CNT_W'(2));
      status.idx_last  = ({1'b0, idx_ff} == (cnt_ff - smsi_pkg::CNT_W'(1)));
      status.div_done  = div_done;
      status.sqrt_done = sqrt_done;
      status.pass2_ok  = (var_ff != '0) && (sdev_ff != '0);
   end

   assign minimum       = out_min_ff;
   assign maximum       = out_max_ff;
   assign mean          = out_mean_ff;
   assign avg_deviation = out_adev_ff;
   assign std_deviation = out_sdev_ff;
   assign variance      = out_var_ff;
   assign skewness      = out_skew_ff;
   assign kurtosis      = out_kurt_ff;
   assign total         = out_sum_ff;
   assign kept_count    = out_cnt_ff;
   assign too_few       = out_few_ff;

endmodule

### rtl/smsi_ctrl.sv
// Controller state machine that sequences loading, both passes and the result beat.
module smsi_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  smsi_pkg::status_type  status,
   output smsi_pkg::cmd_type     cmd
);

   smsi_pkg::state_type state_ff;
   smsi_pkg::state_type state_in;
   logic                out_valid_ff;
   logic                out_valid_in;

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smsi_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mul_sel = smsi_pkg::MUL_AD_AD;
      cmd.div_sel = smsi_pkg::DIV_MEAN;
      cmd.cap     = smsi_pkg::CAP_NONE;

      unique case (state_ff)
         smsi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
            if (req_valid && req_last)
               state_in = smsi_pkg::ST_CHECK;
         end
         smsi_pkg::ST_CHECK: begin
            cmd.clr_stats = 1'b1;
            if (status.n_ge2) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = smsi_pkg::DIV_MEAN;
               state_in      = smsi_pkg::ST_MEAN;
            end else begin
               state_in = smsi_pkg::ST_FINISH;
            end
         end
         smsi_pkg::ST_MEAN: begin
            if (status.div_done) begin
               cmd.cap  = smsi_pkg::CAP_MEAN;
               state_in = smsi_pkg::ST_P1_ADDR;
            end
         end
         smsi_pkg::ST_P1_ADDR: begin
            state_in = smsi_pkg::ST_P1_DIFF;
         end
         smsi_pkg::ST_P1_DIFF: begin
            cmd.diff = 1'b1;
            state_in = smsi_pkg::ST_P1_MUL;
         end
         smsi_pkg::ST_P1_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = smsi_pkg::MUL_AD_AD;
            state_in    = smsi_pkg::ST_P1_ACC;
         end
         smsi_pkg::ST_P1_ACC: begin
            cmd.p1_acc = 1'b1;
            if (status.idx_last) begin
               state_in = smsi_pkg::ST_P1_END;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = smsi_pkg::ST_P1_ADDR;
            end
         end
         smsi_pkg::ST_P1_END: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = smsi_pkg::DIV_ADEV;
            state_in      = smsi_pkg::ST_ADEV;
         end
         smsi_pkg::ST_ADEV: begin
            cmd.div_sel = smsi_pkg::DIV_VAR;
            if (status.div_done) begin
               cmd.cap       = smsi_pkg::CAP_ADEV;
               cmd.div_start = 1'b1;
               state_in      = smsi_pkg::ST_VAR;
            end
         end
         smsi_pkg::ST_VAR: begin
            if (status.div_done) begin
               cmd.cap  = smsi_pkg::CAP_VAR;
               state_in = smsi_pkg::ST_SQRT_GO;
            end
         end
         smsi_pkg::ST_SQRT_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = smsi_pkg::ST_SQRT;
         end
         smsi_pkg::ST_SQRT: begin
            if (status.sqrt_done) begin
               cmd.cap  = smsi_pkg::CAP_SDEV;
               state_in = smsi_pkg::ST_P2_CHECK;
            end
         end
         smsi_pkg::ST_P2_CHECK: begin
            // A zero spread leaves skewness and kurtosis at zero.
            if (status.pass2_ok) begin
               cmd.idx_clr = 1'b1;
               state_in    = smsi_pkg::ST_P2_ADDR;
            end else begin
               state_in = smsi_pkg::ST_FINISH;
            end
         end
         smsi_pkg::ST_P2_ADDR: begin
            state_in = smsi_pkg::ST_P2_DIFF;
         end
         smsi_pkg::ST_P2_DIFF: begin
            cmd.diff = 1'b1;
            state_in = smsi_pkg::ST_P2_ZGO;
         end
         smsi_pkg::ST_P2_ZGO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = smsi_pkg::DIV_Z;
            state_in      = smsi_pkg::ST_P2_ZDIV;
         end
         smsi_pkg::ST_P2_ZDIV: begin
            if (status.div_done) begin
               cmd.cap  = smsi_pkg::CAP_Z;
               state_in = smsi_pkg::ST_P2_SQ;
            end
         end
         smsi_pkg::ST_P2_SQ: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = smsi_pkg::MUL_Z_Z;
            state_in    = smsi_pkg::ST_P2_A2;
         end
         smsi_pkg::ST_P2_A2: begin
            cmd.a2_lat = 1'b1;
            state_in   = smsi_pkg::ST_P2_CUBE;
         end
         smsi_pkg::ST_P2_CUBE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = smsi_pkg::MUL_A2_Z;
            state_in    = smsi_pkg::ST_P2_A3;
         end
         smsi_pkg::ST_P2_A3: begin
            // The cube is summed while the fourth power is formed.
            cmd.s3_acc  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = smsi_pkg::MUL_A2_A2;
            state_in    = smsi_pkg::ST_P2_A4;
         end
         smsi_pkg::ST_P2_A4: begin
            cmd.s4_acc = 1'b1;
            if (status.idx_last) begin
               state_in = smsi_pkg::ST_P2_END;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = smsi_pkg::ST_P2_ADDR;
            end
         end
         smsi_pkg::ST_P2_END: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = smsi_pkg::DIV_SKEW;
            state_in      = smsi_pkg::ST_SKEW;
         end
         smsi_pkg::ST_SKEW: begin
            cmd.div_sel = smsi_pkg::DIV_SKEW;
            if (status.div_done) begin
               cmd.cap       = smsi_pkg::CAP_SKEW;
               cmd.div_start = 1'b1;
               cmd.div_sel   = smsi_pkg::DIV_KURT;
               state_in      = smsi_pkg::ST_KURT;
            end
         end
         smsi_pkg::ST_KURT: begin
            if (status.div_done) begin
               cmd.cap  = smsi_pkg::CAP_KURT;
               state_in = smsi_pkg::ST_FINISH;
            end
         end
         smsi_pkg::ST_FINISH: begin
            // Wait until the previous result beat has left the output register.
            if (!out_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               cmd.clr_acc  = 1'b1;
               state_in     = smsi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smsi_pkg::ST_IDLE;
         end
      endcase

      // Result valid holds until the beat is taken.
      if (cmd.load_out)
         out_valid_in = 1'b1;
      else if (rsp_ready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   assign rsp_valid = out_valid_ff;

endmodule

### rtl/sample_moment_statistics_ignore_top.sv
// Top level of the sample moment statistics block with ignore value and register port.
// Samples are taken one beat per cycle while a data set loads; a kept sample is written to
// a 4096-entry store and folded into count, sum, minimum and maximum. After the beat marked
// last, the block stops taking samples, divides for the mean and makes a second pass over
// the store (address, difference, multiply and accumulate per sample), then divides for
// average deviation and variance and takes a square root; when the spread is nonzero, a
// third pass follows, with one division per sample, then divisions for skewness and kurtosis.
// With fewer than two kept samples the block goes straight to the result beat. The run time
// is set mostly by the shared restoring divider, which yields one quotient bit per cycle. The
// result sits in an output register, so the next data set may load while it waits to be
// taken; a further result waits until it has gone. Write the ignore registers only while no
// data set is in progress.
module sample_moment_statistics_ignore_top (
   input  logic                              clock,
   input  logic                              reset,
   smsi_req_if.sink                          req_ch,
   smsi_rsp_if.source                        rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [smsi_pkg::PADDR_W-1:0]      paddr,
   input  logic [smsi_pkg::PDATA_W-1:0]      pwdata,
   output logic [smsi_pkg::PDATA_W-1:0]      prdata,
   output logic                              pready
);

   logic                                 ign_en_ff;
   logic signed [smsi_pkg::SAMPLE_W-1:0] ign_val_ff;
   logic                                 csr_wr;
   smsi_pkg::cmd_type                    cmd;
   smsi_pkg::status_type                 status;

   // Register writes complete in the access phase.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ign_en_ff  <= 1'b0;
         ign_val_ff <= '0;
      end else if (csr_wr) begin
         unique case (paddr[2])
            smsi_pkg::CSR_IGN_EN:  ign_en_ff  <= pwdata[0];
            smsi_pkg::CSR_IGN_VAL: ign_val_ff <= pwdata[smsi_pkg::SAMPLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register read data.
   always_comb begin
      unique case (paddr[2])
         smsi_pkg::CSR_IGN_EN:  prdata = smsi_pkg::PDATA_W'(ign_en_ff);
         smsi_pkg::CSR_IGN_VAL: prdata = smsi_pkg::PDATA_W'(ign_val_ff);
         default:               prdata = '0;
      endcase
   end

   smsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   smsi_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .ign_en        (ign_en_ff),
      .ign_val       (ign_val_ff),
      .sample        (req_ch.sample),
      .minimum       (rsp_ch.minimum),
      .maximum       (rsp_ch.maximum),
      .mean          (rsp_ch.mean),
      .avg_deviation (rsp_ch.avg_deviation),
      .std_deviation (rsp_ch.std_deviation),
      .variance      (rsp_ch.variance),
      .skewness      (rsp_ch.skewness),
      .kurtosis      (rsp_ch.kurtosis),
      .total         (rsp_ch.total),
      .kept_count    (rsp_ch.kept_count),
      .too_few       (rsp_ch.too_few)
   );

endmodule
